[rtl/core/i2cbm_pkg.sv]
// Shared types and constants for the I2C bit-level master core.
// Holds the phase encoding, operation codes, engine state and result records.
// No dependencies.
package i2cbm_pkg;

  localparam int unsigned OpWidth       = 3;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned BitCntWidth   = 4;
  localparam int unsigned TickWidth     = 8;
  localparam logic [7:0]  AckTimeoutRst = 8'd250;
  localparam logic [3:0]  BitsPerByte   = 4'd8;

  // Operation codes; codes 6 and 7 behave as a plain tick.
  typedef enum logic [OpWidth-1:0] {
    OpTick    = 3'd0,
    OpStart   = 3'd1,
    OpStop    = 3'd2,
    OpWrite   = 3'd3,
    OpRead    = 3'd4,
    OpWaitAck = 3'd5
  } op_e;

  // Sequencer phases, one-hot.
  typedef enum logic [13:0] {
    PhIdle = 14'h0001,  // waiting for a command
    PhS1   = 14'h0002,  // start: both lines high
    PhS2   = 14'h0004,  // start: SDA low, SCL high
    PhP1   = 14'h0008,  // stop: both lines low
    PhP2   = 14'h0010,  // stop: both lines high
    PhWl   = 14'h0020,  // write: data set, SCL low
    PhWh   = 14'h0040,  // write: SCL high
    PhWt   = 14'h0080,  // write: SCL low, next bit
    PhRl   = 14'h0100,  // read: SCL low
    PhRh   = 14'h0200,  // read: SCL high after sampling
    PhAl   = 14'h0400,  // read: ACK bit driven, SCL low
    PhAh   = 14'h0800,  // read: ACK bit, SCL high
    PhK1   = 14'h1000,  // wait-ack: SDA released
    PhKp   = 14'h2000   // wait-ack: polling SDA
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic [TickWidth-1:0]   tick_count;
    logic [BitCntWidth-1:0] bit_count;
    logic [ByteWidth-1:0]   shift_reg;
    logic                   ack_choice;
    logic                   scl;
    logic                   sda;
    logic                   sda_dir;
    logic [ByteWidth-1:0]   rx_byte;
    logic                   fail;
  } state_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy;
    logic                 done;
    logic [ByteWidth-1:0] read_data;
    logic                 ack_failed;
  } result_t;

endpackage

[rtl/core/i2cbm_step.sv]
// Next-state and result logic of the I2C bit-level master for one tick.
// Purely combinational; depends on i2cbm_pkg.
module i2cbm_step import i2cbm_pkg::*; (
  input  state_t               cur_i,
  input  logic [OpWidth-1:0]   operation_i,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 send_ack_i,
  input  logic                 sda_in_i,
  input  logic [TickWidth-1:0] ack_timeout_i,
  output state_t               nxt_o,
  output result_t              res_o
);

  state_t                 nxt;
  logic                   done;
  logic [BitCntWidth-1:0] bit_inc;

  assign bit_inc = cur_i.bit_count + 4'd1;

  always_comb begin
    nxt  = cur_i;
    done = 1'b0;
    if (cur_i.phase == PhIdle) begin
      case (operation_i)
        OpStart: begin
          nxt.sda_dir    = 1'b1;
          nxt.sda        = 1'b1;
          nxt.scl        = 1'b1;
          nxt.tick_count = 8'd4;
          nxt.phase      = PhS1;
        end
        OpStop: begin
          nxt.sda_dir    = 1'b1;
          nxt.scl        = 1'b0;
          nxt.sda        = 1'b0;
          nxt.tick_count = 8'd4;
          nxt.phase      = PhP1;
        end
        OpWrite: begin
          nxt.sda_dir    = 1'b1;
          nxt.scl        = 1'b0;
          nxt.shift_reg  = data_byte_i;
          nxt.bit_count  = '0;
          nxt.sda        = data_byte_i[ByteWidth-1];
          nxt.tick_count = 8'd2;
          nxt.phase      = PhWl;
        end
        OpRead: begin
          nxt.sda_dir    = 1'b0;
          nxt.scl        = 1'b0;
          nxt.ack_choice = send_ack_i;
          nxt.bit_count  = '0;
          nxt.shift_reg  = '0;
          nxt.tick_count = 8'd2;
          nxt.phase      = PhRl;
        end
        OpWaitAck: begin
          nxt.sda_dir    = 1'b0;
          nxt.sda        = 1'b1;
          nxt.fail       = 1'b0;
          nxt.tick_count = 8'd1;
          nxt.phase      = PhK1;
        end
        default: ;
      endcase
    end else if (cur_i.phase == PhKp) begin
      if (!sda_in_i) begin
        nxt.scl   = 1'b0;
        nxt.phase = PhIdle;
        done      = 1'b1;
      end else if (cur_i.tick_count >= ack_timeout_i) begin
        // Timed out: flag it and fall into a stop sequence.
        nxt.fail       = 1'b1;
        nxt.sda_dir    = 1'b1;
        nxt.scl        = 1'b0;
        nxt.sda        = 1'b0;
        nxt.tick_count = 8'd4;
        nxt.phase      = PhP1;
      end else begin
        nxt.tick_count = cur_i.tick_count + 8'd1;
      end
    end else if (cur_i.tick_count > 8'd1) begin
      nxt.tick_count = cur_i.tick_count - 8'd1;
    end else begin
      case (cur_i.phase)
        PhS1: begin
          nxt.sda        = 1'b0;
          nxt.tick_count = 8'd4;
          nxt.phase      = PhS2;
        end
        PhS2: begin
          nxt.scl   = 1'b0;
          nxt.phase = PhIdle;
          done      = 1'b1;
        end
        PhP1: begin
          nxt.scl        = 1'b1;
          nxt.sda        = 1'b1;
          nxt.tick_count = 8'd4;
          nxt.phase      = PhP2;
        end
        PhP2: begin
          nxt.phase = PhIdle;
          done      = 1'b1;
        end
        PhWl: begin
          nxt.scl        = 1'b1;
          nxt.tick_count = 8'd2;
          nxt.phase      = PhWh;
        end
        PhWh: begin
          nxt.scl        = 1'b0;
          nxt.tick_count = 8'd2;
          nxt.phase      = PhWt;
        end
        PhWt: begin
          nxt.shift_reg = {cur_i.shift_reg[ByteWidth-2:0], 1'b0};
          nxt.bit_count = bit_inc;
          if (bit_inc >= BitsPerByte) begin
            nxt.phase = PhIdle;
            done      = 1'b1;
          end else begin
            nxt.sda        = cur_i.shift_reg[ByteWidth-2];
            nxt.tick_count = 8'd2;
            nxt.phase      = PhWl;
          end
        end
        PhRl: begin
          nxt.scl        = 1'b1;
          nxt.shift_reg  = {cur_i.shift_reg[ByteWidth-2:0], sda_in_i};
          nxt.tick_count = 8'd1;
          nxt.phase      = PhRh;
        end
        PhRh: begin
          nxt.bit_count  = bit_inc;
          nxt.scl        = 1'b0;
          nxt.tick_count = 8'd2;
          if (bit_inc >= BitsPerByte) begin
            nxt.rx_byte = cur_i.shift_reg;
            nxt.sda_dir = 1'b1;
            nxt.sda     = ~cur_i.ack_choice;
            nxt.phase   = PhAl;
          end else begin
            nxt.phase = PhRl;
          end
        end
        PhAl: begin
          nxt.scl        = 1'b1;
          nxt.tick_count = 8'd2;
          nxt.phase      = PhAh;
        end
        PhAh: begin
          nxt.scl   = 1'b0;
          nxt.phase = PhIdle;
          done      = 1'b1;
        end
        PhK1: begin
          nxt.scl        = 1'b1;
          nxt.tick_count = '0;
          nxt.phase      = PhKp;
        end
        default: nxt.phase = PhIdle;
      endcase
    end
  end

  assign nxt_o = nxt;

  assign res_o.scl_level  = nxt.scl;
  assign res_o.sda_level  = nxt.sda_dir & nxt.sda;
  assign res_o.sda_drive  = nxt.sda_dir;
  assign res_o.busy       = (nxt.phase != PhIdle);
  assign res_o.done       = done;
  assign res_o.read_data  = nxt.rx_byte;
  assign res_o.ack_failed = nxt.fail;

endmodule

[rtl/core/i2cbm_out_reg.sv]
// Result register of the I2C bit-level master with valid/ready handshake.
// Depends on i2cbm_pkg for the result record.
module i2cbm_out_reg import i2cbm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    can_load_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // A new result may enter whenever the slot is empty or being emptied.
  assign can_load_o = ~valid_q | ready_i;
  assign valid_d    = load_i | (valid_q & ~ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[rtl/core/i2c_bit_level_master_core.sv]
// Top level of the I2C bit-level master core.
// Instantiates i2cbm_step and i2cbm_out_reg; uses types from i2cbm_pkg.
//
// Each input request is one bus tick (nominally one microsecond). While the
// sequencer is idle, the operation field selects start, stop, write byte,
// read byte (ACK or NACK after it) or wait-for-ACK; while it is busy the
// operation is ignored and the request only advances the running sequence,
// with sda_in carrying the sampled SDA level for that tick.
// Every input request produces exactly one result request holding the SCL
// and SDA levels, the SDA drive enable, busy and done flags, the last
// received byte and the wait-ack failure flag.
// The engine state and the result register update on the edge that accepts
// the input. Throughput is one request per cycle while the receiver keeps
// up; the single sequencer state register, updated once per tick, sets it.
// When the result receiver stalls, the result stays held and the input
// channel accepts again as soon as the held result is taken in that cycle.
// The configuration channel writes ack_timeout (reset 250), the number of
// extra high polls allowed before a wait-ack fails; it is always ready.
// Reset leaves the sequencer idle with SCL and SDA driven high and no
// result pending.
module i2c_bit_level_master_core import i2cbm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OpWidth-1:0]   operation_i,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 send_ack_i,
  input  logic                 sda_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 scl_level_o,
  output logic                 sda_level_o,
  output logic                 sda_drive_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic [ByteWidth-1:0] read_data_o,
  output logic                 ack_failed_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TickWidth-1:0] cfg_data_i
);

  state_t               state_q, state_d;
  result_t              res_d, res_q;
  logic [TickWidth-1:0] ack_timeout_q;
  logic                 can_load;
  logic                 in_fire;

  // The configuration register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_valid_i) begin
      ack_timeout_q <= cfg_data_i;
    end
  end

  assign in_ready_o = can_load;
  assign in_fire    = in_valid_i & can_load;

  i2cbm_step u_step (
    .cur_i         (state_q),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_in_i      (sda_in_i),
    .ack_timeout_i (ack_timeout_q),
    .nxt_o         (state_d),
    .res_o         (res_d)
  );

  // Sequencer state advances only on an accepted tick request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PhIdle;
      state_q.tick_count <= '0;
      state_q.bit_count  <= '0;
      state_q.shift_reg  <= '0;
      state_q.ack_choice <= 1'b0;
      state_q.scl        <= 1'b1;
      state_q.sda        <= 1'b1;
      state_q.sda_dir    <= 1'b1;
      state_q.rx_byte    <= '0;
      state_q.fail       <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  i2cbm_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .res_i      (res_d),
    .can_load_o (can_load),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .res_o      (res_q)
  );

  assign scl_level_o  = res_q.scl_level;
  assign sda_level_o  = res_q.sda_level;
  assign sda_drive_o  = res_q.sda_drive;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign read_data_o  = res_q.read_data;
  assign ack_failed_o = res_q.ack_failed;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the I2C bit-level master core.
// Drives bus-tick requests and ack_timeout writes, predicts every result
// request and compares it field by field. Depends on i2cbm_pkg and the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 320;

  // One input request: a bus tick, optionally carrying a command.
  typedef struct packed {
    logic [OpWidth-1:0]   op;
    logic [ByteWidth-1:0] data;
    logic                 ack;
    logic                 sda;
  } bus_req_t;

  // Clock and reset, plus every input of the core with a known start value.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [OpWidth-1:0]   operation_i = '0;
  logic [ByteWidth-1:0] data_byte_i = '0;
  logic                 send_ack_i  = 1'b0;
  logic                 sda_in_i    = 1'b0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [TickWidth-1:0] cfg_data_i  = '0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 scl_level_o;
  logic                 sda_level_o;
  logic                 sda_drive_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic [ByteWidth-1:0] read_data_o;
  logic                 ack_failed_o;
  logic                 cfg_ready_o;

  i2c_bit_level_master_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .data_byte_i  (data_byte_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o),
    .ack_failed_o (ack_failed_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Requests waiting for the driver, and bus results waiting for the core.
  bus_req_t pending_q[$];
  result_t  expected_bus_q[$];

  // Progress counters. All but n_queued advance at the rising edge only, so
  // the stimulus process can wait on them without racing the monitor.
  int unsigned n_queued    = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_errors    = 0;
  int unsigned cycle_count = 0;
  int unsigned cmd_count[8];
  int unsigned timeout_count = 0;

  // Idle shaping for the two channels, set per phase by the stimulus.
  int unsigned in_gap_max  = 8;
  int unsigned out_gap_max = 8;
  int unsigned req_gap     = 0;
  int unsigned res_stall   = 0;
  int unsigned stall_next;
  int unsigned hold_left   = 0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;
  logic        in_taken    = 1'b0;
  logic        out_taken   = 1'b0;
  bus_req_t    drv_next;

  // Shadow of the bus engine: sequencer phase, timing counter, bit counter,
  // shift register, the ACK choice of a read, line levels, SDA direction,
  // the last received byte, the failure flag and the ack_timeout register.
  phase_e               m_phase;
  logic [TickWidth-1:0] m_ticks;
  logic [3:0]           m_bits;
  logic [ByteWidth-1:0] m_shift;
  logic [ByteWidth-1:0] m_rx;
  logic [TickWidth-1:0] m_timeout;
  logic                 m_ack_sel;
  logic                 m_scl;
  logic                 m_sda;
  logic                 m_drive;
  logic                 m_fail;

  // 50 MHz clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Reset is held low at the start and never asserted again.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Both lines go low and the four-tick stop timing begins. Used by the stop
  // command and by a wait-ack that runs out of polls.
  function automatic void enter_stop();
    m_drive = 1'b1;
    m_scl   = 1'b0;
    m_sda   = 1'b0;
    m_ticks = 8'd4;
    m_phase = PhP1;
  endfunction

  // Advance the shadow engine by one accepted tick and return the bus state
  // the core must report for it. Commands are only looked at while idle;
  // codes 6 and 7 fall into the default arm and act as a plain tick.
  function automatic result_t step_engine(input bus_req_t req);
    logic    done;
    result_t res;
    done = 1'b0;
    if (m_phase == PhIdle) begin
      case (req.op)
        OpStart: begin
          m_drive = 1'b1;
          m_sda   = 1'b1;
          m_scl   = 1'b1;
          m_ticks = 8'd4;
          m_phase = PhS1;
        end
        OpStop: enter_stop();
        OpWrite: begin
          m_drive = 1'b1;
          m_scl   = 1'b0;
          m_shift = req.data;
          m_bits  = '0;
          m_sda   = req.data[7];
          m_ticks = 8'd2;
          m_phase = PhWl;
        end
        OpRead: begin
          m_drive   = 1'b0;
          m_scl     = 1'b0;
          m_ack_sel = req.ack;
          m_bits    = '0;
          m_shift   = '0;
          m_ticks   = 8'd2;
          m_phase   = PhRl;
        end
        OpWaitAck: begin
          m_drive = 1'b0;
          m_sda   = 1'b1;
          m_fail  = 1'b0;
          m_ticks = 8'd1;
          m_phase = PhK1;
        end
        default: ;
      endcase
      if (req.op >= OpStart && req.op <= OpWaitAck) cmd_count[req.op]++;
    end else if (m_phase == PhKp) begin
      // One poll per tick: a low SDA is the acknowledge, otherwise count up
      // until the timeout is reached and then fall back to a stop.
      if (!req.sda) begin
        m_scl   = 1'b0;
        m_phase = PhIdle;
        done    = 1'b1;
      end else if (m_ticks >= m_timeout) begin
        m_fail = 1'b1;
        timeout_count++;
        enter_stop();
      end else begin
        m_ticks = m_ticks + 8'd1;
      end
    end else if (m_ticks > 8'd1) begin
      m_ticks = m_ticks - 8'd1;
    end else begin
      case (m_phase)
        PhS1: begin
          m_sda   = 1'b0;
          m_ticks = 8'd4;
          m_phase = PhS2;
        end
        PhS2: begin
          m_scl   = 1'b0;
          m_phase = PhIdle;
          done    = 1'b1;
        end
        PhP1: begin
          m_scl   = 1'b1;
          m_sda   = 1'b1;
          m_ticks = 8'd4;
          m_phase = PhP2;
        end
        PhP2: begin
          m_phase = PhIdle;
          done    = 1'b1;
        end
        PhWl: begin
          m_scl   = 1'b1;
          m_ticks = 8'd2;
          m_phase = PhWh;
        end
        PhWh: begin
          m_scl   = 1'b0;
          m_ticks = 8'd2;
          m_phase = PhWt;
        end
        PhWt: begin
          m_shift = m_shift << 1;
          m_bits  = m_bits + 4'd1;
          if (m_bits >= BitsPerByte) begin
            m_phase = PhIdle;
            done    = 1'b1;
          end else begin
            m_sda   = m_shift[7];
            m_ticks = 8'd2;
            m_phase = PhWl;
          end
        end
        PhRl: begin
          // SDA is sampled on the tick that raises SCL.
          m_scl   = 1'b1;
          m_shift = {m_shift[6:0], req.sda};
          m_ticks = 8'd1;
          m_phase = PhRh;
        end
        PhRh: begin
          m_bits  = m_bits + 4'd1;
          m_scl   = 1'b0;
          m_ticks = 8'd2;
          if (m_bits >= BitsPerByte) begin
            m_rx    = m_shift;
            m_drive = 1'b1;
            m_sda   = ~m_ack_sel;
            m_phase = PhAl;
          end else begin
            m_phase = PhRl;
          end
        end
        PhAl: begin
          m_scl   = 1'b1;
          m_ticks = 8'd2;
          m_phase = PhAh;
        end
        PhAh: begin
          m_scl   = 1'b0;
          m_phase = PhIdle;
          done    = 1'b1;
        end
        PhK1: begin
          m_scl   = 1'b1;
          m_ticks = '0;
          m_phase = PhKp;
        end
        default: m_phase = PhIdle;
      endcase
    end
    res.scl_level  = m_scl;
    res.sda_level  = m_drive ? m_sda : 1'b0;  // a released SDA reads as 0
    res.sda_drive  = m_drive;
    res.busy       = (m_phase != PhIdle);
    res.done       = done;
    res.read_data  = m_rx;
    res.ack_failed = m_fail;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Monitor. Everything the core shows is sampled here at the rising edge:
  // configuration writes, accepted requests (which feed the shadow engine)
  // and delivered results (which are checked against the oldest prediction).
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_phase   = PhIdle;
      m_ticks   = '0;
      m_bits    = '0;
      m_shift   = '0;
      m_rx      = '0;
      m_timeout = AckTimeoutRst;
      m_ack_sel = 1'b0;
      m_scl     = 1'b1;
      m_sda     = 1'b1;
      m_drive   = 1'b1;
      m_fail    = 1'b0;
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      cycle_count++;
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (cfg_valid_i && cfg_ready_o) begin
        m_timeout = cfg_data_i;
        n_cfg++;
      end
      // The result leaving now belongs to an earlier request, so it is
      // checked before this edge's request adds its own prediction.
      if (out_valid_o && out_ready_i) begin
        if (expected_bus_q.size() == 0) begin
          $error("Result request arrived with no prediction waiting");
          n_errors++;
        end else begin
          result_t want;
          want = expected_bus_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(scl_level_o));
          check_field("sda_level", 8'(want.sda_level), 8'(sda_level_o));
          check_field("sda_drive", 8'(want.sda_drive), 8'(sda_drive_o));
          check_field("busy_res", 8'(want.busy), 8'(busy_res_o));
          check_field("done_res", 8'(want.done), 8'(done_res_o));
          check_field("read_data", want.read_data, read_data_o);
          check_field("ack_failed", 8'(want.ack_failed), 8'(ack_failed_o));
          n_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_bus_q.push_back(step_engine({operation_i, data_byte_i, send_ack_i,
                                              sda_in_i}));
        n_accepted++;
      end
    end
  end

  // Request driver. A new request is loaded only once the previous one has
  // been taken, after a random gap drawn for each request; valid is never
  // dropped while a request is still on offer.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_gap    <= 0;
    end else if (!in_valid_i || in_taken) begin
      if (req_gap > 0) begin
        in_valid_i <= 1'b0;
        req_gap    <= req_gap - 1;
      end else if (pending_q.size() > 0) begin
        drv_next    = pending_q.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= drv_next.op;
        data_byte_i <= drv_next.data;
        send_ack_i  <= drv_next.ack;
        sda_in_i    <= drv_next.sda;
        req_gap     <= $urandom_range(0, in_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. After each taken result it stalls for a random number
  // of cycles, and it also stays stalled while the long hold-off runs.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      res_stall   <= 0;
    end else begin
      if (out_taken) stall_next = $urandom_range(0, out_gap_max);
      else stall_next = (res_stall > 0) ? res_stall - 1 : 0;
      res_stall   <= stall_next;
      out_ready_i <= (stall_next == 0) && (hold_left == 0);
    end
  end

  // Long hold-off of the receiver, counted here once the stimulus asks for
  // it. With the sender still offering, the held result blocks the input.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_request(input logic [OpWidth-1:0] op, input logic [7:0] data,
                               input logic ack, input logic sda);
    bus_req_t req;
    req.op   = op;
    req.data = data;
    req.ack  = ack;
    req.sda  = sda;
    pending_q.push_back(req);
    n_queued++;
  endtask

  // Ticks with random content. While the engine is busy the operation field
  // is ignored, so random codes here only matter when it is idle.
  task automatic queue_filler(input int unsigned count);
    repeat (count) queue_request(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Start, stop or write, followed by exactly the ticks the sequence needs.
  task automatic queue_command(input op_e op, input logic [7:0] data);
    queue_request(op, data, 1'($urandom), 1'($urandom));
    queue_filler((op == OpWrite) ? 48 : 8);
  endtask

  // Read one byte: each bit spans three ticks and SDA carries the bit for
  // all three, then four ticks for the ACK or NACK bit.
  task automatic queue_read(input logic ack, input logic [7:0] pattern);
    int b;
    queue_request(OpRead, 8'($urandom), ack, 1'($urandom));
    for (b = 7; b >= 0; b--) begin
      repeat (3) queue_request(3'($urandom), 8'($urandom), 1'($urandom), pattern[b]);
    end
    queue_filler(4);
  endtask

  // Wait for ACK: one tick to release SDA, then polls. Either the slave pulls
  // SDA low after the given number of high polls, or SDA stays high until the
  // timeout runs out and the stop that follows completes.
  task automatic queue_wait_ack(input int unsigned polls_high, input logic give_up);
    queue_request(OpWaitAck, 8'($urandom), 1'($urandom), 1'($urandom));
    queue_filler(1);
    if (give_up) begin
      repeat (int'(m_timeout) + 1)
        queue_request(3'($urandom), 8'($urandom), 1'($urandom), 1'b1);
      queue_filler(8);
    end else begin
      repeat (polls_high) queue_request(3'($urandom), 8'($urandom), 1'($urandom), 1'b1);
      queue_request(3'($urandom), 8'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  // Stop offering until every result is back, then tick the engine until
  // the shadow says it is idle again.
  task automatic drain_engine();
    wait (n_checked == n_queued);
    while (m_phase != PhIdle) begin
      queue_request(OpTick, 8'($urandom), 1'($urandom), 1'($urandom));
      wait (n_checked == n_queued);
    end
  endtask

  // Write ack_timeout with the core idle. A short pause comes before the
  // write is put on the channel.
  task automatic set_ack_timeout(input logic [7:0] value);
    int unsigned seen;
    drain_engine();
    repeat (2) @(posedge clk_i);
    seen = n_cfg;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    wait (n_cfg != seen);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus.
  initial begin
    int unsigned p;
    int unsigned pick;
    int unsigned polls;
    int unsigned phase_base;
    int unsigned seq;
    logic        give_up;
    logic [7:0]  phase_to;

    wait (rst_ni);
    @(posedge clk_i);

    // Directed part. The first wait-ack runs out the reset value of the
    // timeout, then the rest uses a zero timeout.
    queue_wait_ack(0, 1'b1);
    set_ack_timeout(8'd0);
    queue_command(OpStart, 8'h00);
    queue_command(OpWrite, 8'hFF);
    queue_command(OpWrite, 8'h00);
    queue_wait_ack(0, 1'b0);
    queue_read(1'b1, 8'hFF);
    queue_read(1'b0, 8'h00);
    queue_wait_ack(0, 1'b1);
    queue_command(OpStop, 8'hFF);
    queue_request(3'd6, 8'hFF, 1'b1, 1'b1);
    queue_request(3'd7, 8'h00, 1'b0, 1'b0);
    queue_request(OpTick, 8'h5A, 1'b1, 1'b0);
    // A write arriving while the start is running must be ignored.
    queue_request(OpStart, 8'h00, 1'b0, 1'b1);
    queue_request(OpWrite, 8'hA5, 1'b1, 1'b0);
    queue_filler(7);
    queue_command(OpStop, 8'h00);

    // Random part: five phases with their own timeout and idle shaping.
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin phase_to = 8'd255; in_gap_max = 8; out_gap_max = 8; end
        1: begin phase_to = 8'd3; in_gap_max = 0; out_gap_max = 0; end
        2: begin phase_to = 8'($urandom_range(1, 40)); in_gap_max = 8; out_gap_max = 0; end
        3: begin phase_to = 8'd0; in_gap_max = 0; out_gap_max = 8; end
        default: begin phase_to = 8'($urandom_range(4, 12)); in_gap_max = 8; out_gap_max = 8; end
      endcase
      set_ack_timeout(phase_to);
      phase_base = n_queued;
      seq = 0;
      while (n_queued - phase_base < PhaseItems) begin
        // Back-to-back phase: once the queue is well stocked, the receiver
        // holds off so the core fills up and stalls its input.
        if (p == 1 && seq == 10) hold_req = 1'b1;
        seq++;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          queue_command(OpStart, 8'($urandom));
        end else if (pick < 22) begin
          queue_command(OpStop, 8'($urandom));
        end else if (pick < 42) begin
          queue_command(OpWrite, 8'($urandom));
        end else if (pick < 62) begin
          queue_read(1'($urandom), 8'($urandom));
        end else if (pick < 80) begin
          if (m_timeout <= 8'd16) give_up = ($urandom_range(0, 3) == 0);
          else give_up = ($urandom_range(0, 11) == 0);
          // Now and then the acknowledge comes on the very last allowed poll.
          if ($urandom_range(0, 9) == 0) polls = 32'(m_timeout);
          else polls = $urandom_range(0, (m_timeout < 8'd6) ? 32'(m_timeout) : 32'd6);
          queue_wait_ack(polls, give_up);
        end else begin
          // Noise: a random request and a few random ticks, which may start
          // a sequence that the next command then runs into.
          queue_filler(1 + $urandom_range(0, 20));
          if ($urandom_range(0, 1) == 0) drain_engine();
        end
      end
    end

    drain_engine();
    repeat (3) @(posedge clk_i);
    if (expected_bus_q.size() != 0) begin
      $error("%0d predicted results never arrived", expected_bus_q.size());
      n_errors++;
    end
    $display("Run covered %0d requests, %0d checked results, %0d timeout writes, %0d cycles.",
             n_accepted, n_checked, n_cfg, cycle_count);
    $display("Commands taken: start %0d, stop %0d, write %0d, read %0d, wait-ack %0d",
             cmd_count[OpStart], cmd_count[OpStop], cmd_count[OpWrite], cmd_count[OpRead],
             cmd_count[OpWaitAck]);
    $display("Wait-acks that timed out: %0d.", timeout_count);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    wait (cycle_count >= CycleLimit);
    $error("Run did not finish within %0d cycles", CycleLimit);
    $display("FAILURE");
    $finish;
  end

endmodule
